// ===== hw/rtl/fsbpm_pkg.sv =====
// types, constants and helper functions for the four-slot bank-paged memory
// used by four_slot_bank_paged_memory and its port checker; no dependencies
package fsbpm_pkg;

  localparam int BLOCK_COUNT = 32;
  localparam int BLOCK_BYTES = 16384;
  localparam int MIN_BLOCKS  = 16;

  localparam int STORE_BYTES = BLOCK_COUNT * BLOCK_BYTES;
  localparam int BLOCK_W     = $clog2(BLOCK_COUNT);
  localparam int OFFS_W      = $clog2(BLOCK_BYTES);
  localparam int ADDR_W      = BLOCK_W + OFFS_W;
  localparam int POP_W       = $clog2(BLOCK_COUNT + 1);
  localparam int CFG_W       = 6;
  localparam int CLAMP_W     = (POP_W > CFG_W) ? POP_W : CFG_W;
  localparam int EXT_BLK_W   = 7;
  localparam int EXT_W       = (POP_W > EXT_BLK_W) ? POP_W : EXT_BLK_W;
  localparam int REM_STEPS   = BLOCK_COUNT / MIN_BLOCKS;
  localparam int EXT_STEPS   = 128 / BLOCK_COUNT;

  localparam int CPU_ADDR_W = 16;
  localparam int PORT_W     = 8;
  localparam int DATA_W     = 8;
  localparam int OP_W       = 2;
  localparam int IN_TDATA_W = CPU_ADDR_W + PORT_W + DATA_W;

  localparam logic [PORT_W-1:0] BANK_PORT_FIRST = 8'hF0;
  localparam logic [PORT_W-1:0] BANK_PORT_LAST  = 8'hF3;
  localparam logic [DATA_W-1:0] LOCK_RESET      = 8'hF0;

  typedef enum logic [OP_W-1:0] {
    OP_MEM_READ   = 2'd0,
    OP_MEM_WRITE  = 2'd1,
    OP_BANK_WRITE = 2'd2,
    OP_LOCK_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // lock bits per slot: 0 -> bit 6, 1 -> bit 4, 2 -> bit 5, 3 -> bit 7
  function automatic logic slot_locked(input logic [DATA_W-1:0] lock,
                                       input logic [1:0] slot);
    logic bit_sel;
    case (slot)
      2'd0:    bit_sel = lock[6];
      2'd1:    bit_sel = lock[4];
      2'd2:    bit_sel = lock[5];
      default: bit_sel = lock[7];
    endcase
    return bit_sel;
  endfunction

  function automatic logic [POP_W-1:0] clamp_blocks(input logic [CFG_W-1:0] v);
    logic [CLAMP_W-1:0] w;
    logic [POP_W-1:0] r;
    w = CLAMP_W'(v);
    if (w < CLAMP_W'(MIN_BLOCKS)) begin
      r = POP_W'(MIN_BLOCKS);
    end else if (w > CLAMP_W'(BLOCK_COUNT)) begin
      r = POP_W'(BLOCK_COUNT);
    end else begin
      r = w[POP_W-1:0];
    end
    return r;
  endfunction

  // extended-mode block number reduced modulo the block count
  function automatic logic [BLOCK_W-1:0] ext_block(input logic [EXT_BLK_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    for (int i = 0; i < EXT_STEPS; i++) begin
      if (w >= EXT_W'(BLOCK_COUNT)) w = w - EXT_W'(BLOCK_COUNT);
    end
    return w[BLOCK_W-1:0];
  endfunction

  // block wrapped modulo the populated count
  function automatic logic [BLOCK_W-1:0] wrap_block(input logic [BLOCK_W-1:0] blk,
                                                    input logic [POP_W-1:0] n);
    logic [POP_W-1:0] w;
    w = POP_W'(blk);
    for (int i = 0; i < REM_STEPS; i++) begin
      if (w >= n) w = w - n;
    end
    return w[BLOCK_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/four_slot_bank_paged_memory.sv =====
// four-slot bank-paged memory: slot maps, lock byte and the ram store
// depends on fsbpm_pkg
//
// The block takes one item per cycle while its result is not stalled and returns one
// result per item, in the cycle after acceptance; read data comes from the registered read
// port of the ram store. After reset the store is cleared one byte a cycle, BLOCK_COUNT *
// BLOCK_BYTES bytes (524288 as built), during which s_tready stays low; configuration writes
// are taken at any time. A read right after a write to the same byte sees the new value.
module four_slot_bank_paged_memory (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // cpu_address [15:0], port_number [23:16], data_byte [31:24]
  input  logic [fsbpm_pkg::IN_TDATA_W-1:0] s_tdata,
  // op [1:0]
  input  logic [fsbpm_pkg::OP_W-1:0]  s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // read_data [7:0]
  output logic [fsbpm_pkg::DATA_W-1:0] m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fsbpm_pkg::CFG_W-1:0] cfg_data
);
  import fsbpm_pkg::*;

  state_t state, state_next;
  logic [ADDR_W-1:0] clear_ptr;
  logic [BLOCK_W-1:0] read_map [4];
  logic [BLOCK_W-1:0] write_map [4];
  logic [DATA_W-1:0] lock_byte;
  logic [POP_W-1:0] populated;
  logic read_flag;

  logic [DATA_W-1:0] ram [STORE_BYTES];
  logic [DATA_W-1:0] mem_q;
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic accept;
  op_t op;
  logic [CPU_ADDR_W-1:0] cpu_address;
  logic [PORT_W-1:0] port_number;
  logic [DATA_W-1:0] data_byte;
  logic [1:0] slot, bank_slot;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic bank_hit;

  assign op          = op_t'(s_tuser);
  assign cpu_address = s_tdata[CPU_ADDR_W-1:0];
  assign port_number = s_tdata[CPU_ADDR_W +: PORT_W];
  assign data_byte   = s_tdata[CPU_ADDR_W+PORT_W +: DATA_W];
  assign slot        = cpu_address[CPU_ADDR_W-1 -: 2];
  assign bank_slot   = port_number[1:0];
  assign bank_hit    = port_number inside {[BANK_PORT_FIRST:BANK_PORT_LAST]};

  assign s_tready  = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = read_flag ? mem_q : '0;

  assign rd_addr = {wrap_block(read_map[slot], populated), cpu_address[OFFS_W-1:0]};
  assign wr_addr = {wrap_block(write_map[slot], populated), cpu_address[OFFS_W-1:0]};

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr;
    mem_wdata  = data_byte;
    mem_re     = accept && (op == OP_MEM_READ);
    mem_raddr  = rd_addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_ptr;
        mem_wdata = '0;
        if (clear_ptr == ADDR_W'(STORE_BYTES - 1)) state_next = ST_RUN;
      end
      ST_RUN: begin
        mem_we = accept && (op == OP_MEM_WRITE);
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) ram[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= ram[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_ptr <= '0;
      m_tvalid  <= 1'b0;
      read_flag <= 1'b0;
      lock_byte <= LOCK_RESET;
      populated <= POP_W'(MIN_BLOCKS);
      for (int i = 0; i < 4; i++) begin
        read_map[i]  <= BLOCK_W'(i);
        write_map[i] <= BLOCK_W'(i);
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_ptr <= clear_ptr + ADDR_W'(1);
      if (cfg_valid && cfg_ready) populated <= clamp_blocks(cfg_data);
      if (accept) begin
        m_tvalid  <= 1'b1;
        read_flag <= (op == OP_MEM_READ);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && op == OP_LOCK_WRITE) lock_byte <= data_byte;
      if (accept && op == OP_BANK_WRITE && bank_hit) begin
        if (data_byte[7]) begin
          read_map[bank_slot]  <= ext_block(data_byte[EXT_BLK_W-1:0]);
          write_map[bank_slot] <= ext_block(data_byte[EXT_BLK_W-1:0]);
        end else begin
          write_map[bank_slot] <= BLOCK_W'(data_byte[2:0]);
          if (slot_locked(lock_byte, bank_slot)) begin
            read_map[bank_slot] <= BLOCK_W'(data_byte[2:0]);
          end else begin
            read_map[bank_slot] <= BLOCK_W'(data_byte[6:4]);
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/fsbpm_checker.sv =====
// port-level checks for four_slot_bank_paged_memory, attached by bind
// depends on fsbpm_pkg
module fsbpm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [fsbpm_pkg::OP_W-1:0]       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [fsbpm_pkg::DATA_W-1:0]     m_tdata
);
  import fsbpm_pkg::*;

  // a result appears only after an item was taken
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without accepted item");

  // the single output slot is never overrun
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !(m_tvalid && !m_tready))
    else $error("item accepted while result stalled");

  // anything but a memory read returns zero in the next cycle
  a_zero_on_non_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != OP_MEM_READ) |=> (m_tvalid && m_tdata == '0))
    else $error("non-read item gave nonzero data");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind four_slot_bank_paged_memory fsbpm_checker u_fsbpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/four_slot_bank_paged_memory_checker.sv =====
// port checker for four_slot_bank_paged_memory: keeps its own slot maps, lock byte
// and ram image, predicts read_data per accepted item and compares results in order
// depends on fsbpm_pkg
`timescale 1ns / 1ps

module four_slot_bank_paged_memory_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  // cpu_address [15:0], port_number [23:16], data_byte [31:24]
  input  logic [fsbpm_pkg::IN_TDATA_W-1:0] s_tdata,
  // op [1:0]
  input  logic [fsbpm_pkg::OP_W-1:0]       s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data [7:0]
  input  logic [fsbpm_pkg::DATA_W-1:0]     m_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [fsbpm_pkg::CFG_W-1:0]      cfg_data,
  output int                               mismatches,
  output int                               pending_reads
);
  import fsbpm_pkg::*;

  logic [BLOCK_W-1:0] rd_bank [0:3];
  logic [BLOCK_W-1:0] wr_bank [0:3];
  logic [DATA_W-1:0]  lock_reg;
  int unsigned        fitted_blocks;
  logic [DATA_W-1:0]  ram_image [int unsigned];
  logic [DATA_W-1:0]  expected_reads [$];

  initial begin
    mismatches = 0;
    pending_reads = 0;
  end

  function automatic int unsigned fitted_from(input logic [CFG_W-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n < MIN_BLOCKS) begin
      n = MIN_BLOCKS;
    end else if (n > BLOCK_COUNT) begin
      n = BLOCK_COUNT;
    end
    return n;
  endfunction

  function automatic int unsigned byte_index(input logic [BLOCK_W-1:0] blk,
                                             input logic [CPU_ADDR_W-1:0] addr);
    int unsigned b;
    b = 32'(blk);
    if (b >= fitted_blocks) begin
      b = b % fitted_blocks;
    end
    return (b * BLOCK_BYTES + 32'(addr[OFFS_W-1:0])) % STORE_BYTES;
  endfunction

  function automatic logic lock_set(input logic [1:0] slot);
    logic hit;
    case (slot)
      2'd0:    hit = lock_reg[6];
      2'd1:    hit = lock_reg[4];
      2'd2:    hit = lock_reg[5];
      default: hit = lock_reg[7];
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    logic [CPU_ADDR_W-1:0] addr;
    logic [PORT_W-1:0]     port;
    logic [DATA_W-1:0]     data;
    logic [DATA_W-1:0]     want;
    logic [1:0]            slot;
    logic [1:0]            bank_slot;
    logic [BLOCK_W-1:0]    blk;
    int unsigned           idx;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rd_bank[i] = BLOCK_W'(i);
        wr_bank[i] = BLOCK_W'(i);
      end
      lock_reg = LOCK_RESET;
      fitted_blocks = MIN_BLOCKS;
      ram_image.delete();
      expected_reads.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reads.size() == 0) begin
          $error("read_data unexpected result: actual %02h", m_tdata);
          mismatches++;
        end else begin
          want = expected_reads.pop_front();
          if (m_tdata !== want) begin
            $error("read_data mismatch: expected %02h actual %02h", want, m_tdata);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        fitted_blocks = fitted_from(cfg_data);
      end
      if (s_tvalid && s_tready) begin
        addr = s_tdata[CPU_ADDR_W-1:0];
        port = s_tdata[CPU_ADDR_W +: PORT_W];
        data = s_tdata[CPU_ADDR_W+PORT_W +: DATA_W];
        slot = addr[15:14];
        want = '0;
        case (op_t'(s_tuser))
          OP_MEM_READ: begin
            idx = byte_index(rd_bank[slot], addr);
            want = ram_image.exists(idx) ? ram_image[idx] : '0;
          end
          OP_MEM_WRITE: begin
            ram_image[byte_index(wr_bank[slot], addr)] = data;
          end
          OP_BANK_WRITE: begin
            if (port >= BANK_PORT_FIRST && port <= BANK_PORT_LAST) begin
              bank_slot = port[1:0];
              if (data[7]) begin
                blk = BLOCK_W'(int'(data[6:0]) % BLOCK_COUNT);
                rd_bank[bank_slot] = blk;
                wr_bank[bank_slot] = blk;
              end else begin
                wr_bank[bank_slot] = BLOCK_W'(data[2:0]);
                rd_bank[bank_slot] = lock_set(bank_slot) ? BLOCK_W'(data[2:0])
                                                         : BLOCK_W'(data[6:4]);
              end
            end
          end
          default: begin
            lock_reg = data;
          end
        endcase
        expected_reads.push_back(want);
      end
    end
    pending_reads = expected_reads.size();
  end

endmodule

// ===== tb/sv/four_slot_bank_paged_memory_tb.sv =====
// testbench top for four_slot_bank_paged_memory: directed and random cpu accesses
// over several block counts, random idling and stalls; checking in the port checker
// depends on fsbpm_pkg, four_slot_bank_paged_memory, four_slot_bank_paged_memory_checker
`timescale 1ns / 1ps

module four_slot_bank_paged_memory_tb;
  import fsbpm_pkg::*;

  localparam int STALL_LIMIT    = 1600000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS    = 320;
  localparam int CALM_ITEMS     = 200;
  localparam int SETTLE_CYCLES  = 4;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DATA_W-1:0]     m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  int          mismatches;
  int          pending_reads;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          rx_hold_req = 1'b0;

  always #4 clk = ~clk;

  four_slot_bank_paged_memory i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  four_slot_bank_paged_memory_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_reads (pending_reads)
  );

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random idling, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_idle_on) begin
        m_tready <= ($urandom_range(99) >= 25);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_t op, input logic [CPU_ADDR_W-1:0] addr,
                           input logic [PORT_W-1:0] port, input logic [DATA_W-1:0] data);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, port, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_reads();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reads != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offsets cluster at both ends of a block so reads meet earlier writes
  task automatic random_access();
    logic [CPU_ADDR_W-1:0] addr;
    logic [PORT_W-1:0]     port;
    logic [DATA_W-1:0]     data;
    int unsigned           pick;
    op_t                   op;
    addr = CPU_ADDR_W'($urandom());
    case ($urandom_range(3))
      0, 1:    addr[13:0] = 14'($urandom_range(31));
      2:       addr[13:0] = 14'(16383 - $urandom_range(31));
      default: addr[13:0] = 14'($urandom());
    endcase
    port = PORT_W'($urandom());
    if ($urandom_range(99) < 85) begin
      port = BANK_PORT_FIRST + PORT_W'($urandom_range(3));
    end
    data = DATA_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 35) begin
      op = OP_MEM_READ;
    end else if (pick < 75) begin
      op = OP_MEM_WRITE;
    end else if (pick < 90) begin
      op = OP_BANK_WRITE;
    end else begin
      op = OP_LOCK_WRITE;
    end
    send_item(op, addr, port, data);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_blocks [6];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    phase_blocks = '{6'd0, 6'd63, 6'd16, 6'd32, 6'd24, CFG_W'($urandom_range(63))};
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset map, store cleared, field extremes
    send_item(OP_MEM_READ,   16'h0000, 8'h00, 8'h00);
    send_item(OP_MEM_READ,   16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_MEM_WRITE,  16'h0000, 8'h00, 8'hFF);
    send_item(OP_MEM_WRITE,  16'hFFFF, 8'hFF, 8'h5A);
    send_item(OP_MEM_WRITE,  16'h4000, 8'h12, 8'hA5);
    send_item(OP_MEM_READ,   16'h0000, 8'h34, 8'h00);
    send_item(OP_MEM_READ,   16'hFFFF, 8'h00, 8'h00);
    send_item(OP_MEM_READ,   16'h4000, 8'h00, 8'h00);
    // ports just outside the bank range are ignored
    send_item(OP_BANK_WRITE, 16'h0000, 8'hEF, 8'h83);
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF4, 8'h83);
    send_item(OP_BANK_WRITE, 16'h0000, 8'h00, 8'hFF);
    send_item(OP_BANK_WRITE, 16'h0000, 8'hFF, 8'hFF);
    // extended mode, block beyond the fitted count wraps
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF0, 8'hFF);
    send_item(OP_MEM_WRITE,  16'h0001, 8'h00, 8'h3C);
    send_item(OP_MEM_READ,   16'h0001, 8'h00, 8'h00);
    // standard mode with slot lock set, read follows write
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF1, 8'h70);
    send_item(OP_MEM_READ,   16'h4000, 8'h00, 8'h00);
    // lock cleared, separate read and write banks
    send_item(OP_LOCK_WRITE, 16'hFFFF, 8'hFF, 8'h00);
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF2, 8'h53);
    send_item(OP_MEM_WRITE,  16'h8002, 8'h00, 8'h99);
    send_item(OP_MEM_READ,   16'h8002, 8'h00, 8'h00);
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF3, 8'h80);
    send_item(OP_MEM_READ,   16'hC000, 8'h00, 8'h00);
    send_item(OP_LOCK_WRITE, 16'h0000, 8'h00, 8'hFF);
    send_item(OP_BANK_WRITE, 16'h0000, 8'hF3, 8'h07);

    for (int p = 0; p < 6; p++) begin
      drain_reads();
      write_blocks(phase_blocks[p]);
      if (p == 3) begin
        rx_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        tx_idle_on = !(p == 2 && i < CALM_ITEMS);
        rx_idle_on = tx_idle_on;
        random_access();
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
    end

    drain_reads();
    if (mismatches == 0 && pending_reads == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
